// File: rtl/lab_pkg.sv
// Package: shared types, fixed-point constants and rounding helpers for the Lab to RGB converter.
package lab_pkg;

	localparam int QB = 20;
	localparam int VW = 48;
	localparam int DW = 40;

	typedef logic signed [VW-1:0] q_t;
	typedef logic signed [63:0] p_t;

	localparam p_t Q_ONE = p_t'(1) <<< QB;
	localparam p_t Q_HALF = p_t'(1) <<< (QB - 1);

	localparam p_t K_THRESH = 64'sd216943;
	localparam p_t K_16_116 = 64'sd144631;
	localparam p_t K_WHITE_X = 64'sd996640;
	localparam p_t K_WHITE_Z = 64'sd1141721;

	localparam p_t M_RX = 64'sd3397863;
	localparam p_t M_RY = 64'sd1611807;
	localparam p_t M_RZ = 64'sd522748;
	localparam p_t M_GX = 64'sd1016349;
	localparam p_t M_GY = 64'sd1967140;
	localparam p_t M_GZ = 64'sd43575;
	localparam p_t M_BX = 64'sd58346;
	localparam p_t M_BY = 64'sd213937;
	localparam p_t M_BZ = 64'sd1108581;

	typedef struct packed {
		logic [14:0]        lightness;
		logic signed [15:0] a_chroma;
		logic signed [15:0] b_chroma;
		logic               line_end;
		logic               frame_end;
	} lab_in_t;

	typedef struct packed {
		logic [9:0] red;
		logic [9:0] green;
		logic [9:0] blue;
		logic       line_end_out;
		logic       frame_end_out;
	} rgb_out_t;

	// Q.20 product back to Q.20, round to nearest, ties away from zero
	function automatic q_t qrnd(input p_t p);
		p_t r;
		if (p >= 0) begin
			r = (p + Q_HALF) >>> QB;
		end else begin
			r = (p + Q_HALF - 1) >>> QB;
		end
		return q_t'(r);
	endfunction

	// Q.20 channel to 10-bit code with saturation
	function automatic logic [9:0] to_out10(input q_t ch);
		p_t v;
		p_t r;
		logic [9:0] o;
		v = p_t'(ch) * 64'sd1023 + Q_HALF;
		r = v >>> QB;
		if (v <= 0) begin
			o = '0;
		end else if (r > 64'sd1023) begin
			o = 10'd1023;
		end else begin
			o = r[9:0];
		end
		return o;
	endfunction

endpackage

// File: rtl/lab_cdiv.sv
// Pipelined signed division by a constant, rounded to nearest with ties away from zero.
module lab_cdiv import lab_pkg::*; #(
	parameter longint DIVISOR = 116,
	parameter int NW = 40
) (
	input  logic                 clk,
	input  logic signed [NW-1:0] n,
	output logic signed [NW-1:0] q
);

	localparam int S = NW + 1;
	localparam int PW = NW + S + 1;
	localparam longint unsigned MUL = (64'd1 << S) / DIVISOR;

	logic [NW:0] mag_s1, mag_s2;
	logic        neg_s1, neg_s2;
	logic [NW:0] q0_s2;
	logic [PW-1:0] prod;
	logic [NW:0] rem;
	logic [NW:0] qc;
	logic signed [NW-1:0] q_s3;

	assign prod = PW'(mag_s1) * PW'(MUL);
	assign rem = mag_s2 - (NW+1)'(q0_s2 * (NW+1)'(DIVISOR));
	assign qc = (rem >= (NW+1)'(DIVISOR)) ? q0_s2 + 1'b1 : q0_s2;

	always_ff @(posedge clk) begin
		neg_s1 <= n < 0;
		mag_s1 <= ((n < 0) ? -((NW+1)'(n)) : (NW+1)'(n)) + (NW+1)'(DIVISOR / 2);
		neg_s2 <= neg_s1;
		mag_s2 <= mag_s1;
		q0_s2 <= (NW+1)'(prod >> S);
		q_s3 <= neg_s2 ? -(NW'(qc)) : NW'(qc);
	end

	assign q = q_s3;

endmodule

// File: rtl/lab_inv.sv
// Inverse Lab companding: cube above the threshold or when force_cube is set, linear segment below, five stages.
module lab_inv import lab_pkg::*; (
	input  logic clk,
	input  q_t   t,
	input  logic force_cube,
	output q_t   f
);

	localparam int HW = VW / 2;

	q_t   t_s1, t_s2, sq_s2, cb_s4, f_s5;
	p_t   hh_s1, hl_s1, ll_s1;
	p_t   a_s3, b_s3, c_s3, d_s3;
	logic sel_s1, sel_s2, sel_s3, sel_s4;
	logic signed [DW-1:0] n_s1, lin;
	logic signed [HW-1:0] th, sh, uh;
	logic [HW-1:0]        tl, sl, ul;

	// square and cube each split into half-width partial products over two stages
	assign th = t[VW-1:HW];
	assign tl = t[HW-1:0];
	assign sh = sq_s2[VW-1:HW];
	assign sl = sq_s2[HW-1:0];
	assign uh = t_s2[VW-1:HW];
	assign ul = t_s2[HW-1:0];

	always_ff @(posedge clk) begin
		t_s1 <= t;
		hh_s1 <= p_t'(th) * p_t'(th);
		hl_s1 <= p_t'(th) * p_t'(tl);
		ll_s1 <= p_t'(tl) * p_t'(tl);
		n_s1 <= DW'((p_t'(t) - K_16_116) * 64'sd1000);
		sel_s1 <= force_cube || (p_t'(t) > K_THRESH);
		t_s2 <= t_s1;
		sq_s2 <= qrnd((hh_s1 <<< (2 * HW)) + (hl_s1 <<< (HW + 1)) + ll_s1);
		sel_s2 <= sel_s1;
		a_s3 <= p_t'(sh) * p_t'(uh);
		b_s3 <= p_t'(sh) * p_t'(ul);
		c_s3 <= p_t'(sl) * p_t'(uh);
		d_s3 <= p_t'(sl) * p_t'(ul);
		sel_s3 <= sel_s2;
		cb_s4 <= qrnd((a_s3 <<< (2 * HW)) + ((b_s3 + c_s3) <<< HW) + d_s3);
		sel_s4 <= sel_s3;
		f_s5 <= sel_s4 ? cb_s4 : q_t'(lin);
	end

	lab_cdiv #(.DIVISOR(7787), .NW(DW)) u_lin (.clk(clk), .n(n_s1), .q(lin));

	assign f = f_s5;

endmodule

// File: rtl/lab_mat.sv
// White point scaling, sRGB matrix and 10-bit output conversion, four stages.
module lab_mat import lab_pkg::*; (
	input  logic       clk,
	input  q_t         xi,
	input  q_t         yi,
	input  q_t         zi,
	output logic [9:0] red,
	output logic [9:0] green,
	output logic [9:0] blue
);

	q_t x_s1, y_s1, z_s1;
	q_t rx_s2, ry_s2, rz_s2, gx_s2, gy_s2, gz_s2, bx_s2, by_s2, bz_s2;
	q_t r_s3, g_s3, b_s3;
	logic [9:0] r_s4, g_s4, b_s4;

	always_ff @(posedge clk) begin
		x_s1 <= qrnd(K_WHITE_X * p_t'(xi));
		y_s1 <= yi;
		z_s1 <= qrnd(K_WHITE_Z * p_t'(zi));
		rx_s2 <= qrnd(M_RX * p_t'(x_s1));
		ry_s2 <= qrnd(M_RY * p_t'(y_s1));
		rz_s2 <= qrnd(M_RZ * p_t'(z_s1));
		gx_s2 <= qrnd(M_GX * p_t'(x_s1));
		gy_s2 <= qrnd(M_GY * p_t'(y_s1));
		gz_s2 <= qrnd(M_GZ * p_t'(z_s1));
		bx_s2 <= qrnd(M_BX * p_t'(x_s1));
		by_s2 <= qrnd(M_BY * p_t'(y_s1));
		bz_s2 <= qrnd(M_BZ * p_t'(z_s1));
		r_s3 <= rx_s2 - ry_s2 - rz_s2;
		g_s3 <= -gx_s2 + gy_s2 + gz_s2;
		b_s3 <= bx_s2 - by_s2 + bz_s2;
		r_s4 <= to_out10(r_s3);
		g_s4 <= to_out10(g_s3);
		b_s4 <= to_out10(b_s3);
	end

	assign red = r_s4;
	assign green = g_s4;
	assign blue = b_s4;

endmodule

// File: rtl/cielab_to_linear_rgb10.sv
// Top level: CIELab (D65) pixel stream to 10-bit linear RGB.
//
// Input channel: a transaction is taken at each rising edge with start high
// and busy low. busy is always low, so one pixel can enter every clock.
// Output channel: result holds one converted pixel for exactly one cycle,
// marked by done; the receiver takes it at the end of that cycle and cannot
// hold it off. line_end and frame_end ride along unchanged.
// Path: the constant dividers, the inverse companding and the matrix, in that
// order. Throughput: one pixel per clock, set by the fully pipelined
// datapath (constant dividers, cube multipliers, matrix multipliers).
// Reset: arst_n clears all valid bits at once; nothing is in flight after
// reset and done stays low until a new pixel has passed the pipeline.
// There is no stall path: results appear in input order, one per pixel.
module cielab_to_linear_rgb10 import lab_pkg::*; #(
	parameter int INPUT_FRACTION_BITS = 8
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	input  lab_in_t  pixel,
	output logic     done,
	output rgb_out_t result
);

	localparam int LAT = 13;
	localparam int UP = QB - INPUT_FRACTION_BITS;

	logic signed [DW-1:0] l20, a20, b20, fy_n, ylin_n;
	logic signed [DW-1:0] fy, da, db, ylin;
	logic                 ybr;
	logic [LAT-1:0]       vld_q;
	logic [1:0]           meta_q [LAT];
	logic                 ybr_q [9];
	q_t                   ylin_q [6];
	q_t                   fx_s4, fy_s4, fz_s4;
	q_t                   xi, yc, zi, yi;

	assign busy = 1'b0;

	assign l20 = DW'(pixel.lightness) <<< UP;
	assign a20 = DW'(pixel.a_chroma) <<< UP;
	assign b20 = DW'(pixel.b_chroma) <<< UP;
	assign fy_n = l20 + DW'(Q_ONE * 64'sd16);
	assign ylin_n = l20 * DW'(10);
	assign ybr = p_t'(l20) > Q_ONE * 64'sd8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[LAT-2:0], start & ~busy};
		end
	end

	always_ff @(posedge clk) begin
		meta_q[0] <= {pixel.line_end, pixel.frame_end};
		for (int i = 1; i < LAT; i++) begin
			meta_q[i] <= meta_q[i-1];
		end
		ybr_q[0] <= ybr;
		for (int i = 1; i < 9; i++) begin
			ybr_q[i] <= ybr_q[i-1];
		end
		ylin_q[0] <= q_t'(ylin);
		for (int i = 1; i < 6; i++) begin
			ylin_q[i] <= ylin_q[i-1];
		end
		fy_s4 <= q_t'(fy);
		fx_s4 <= q_t'(fy) + q_t'(da);
		fz_s4 <= q_t'(fy) - q_t'(db);
	end

	lab_cdiv #(.DIVISOR(116), .NW(DW)) u_fy (.clk(clk), .n(fy_n), .q(fy));
	lab_cdiv #(.DIVISOR(500), .NW(DW)) u_da (.clk(clk), .n(a20), .q(da));
	lab_cdiv #(.DIVISOR(200), .NW(DW)) u_db (.clk(clk), .n(b20), .q(db));
	lab_cdiv #(.DIVISOR(9033), .NW(DW)) u_yl (.clk(clk), .n(ylin_n), .q(ylin));

	lab_inv u_inv_x (.clk(clk), .t(fx_s4), .force_cube(1'b0), .f(xi));
	lab_inv u_inv_y (.clk(clk), .t(fy_s4), .force_cube(1'b1), .f(yc));
	lab_inv u_inv_z (.clk(clk), .t(fz_s4), .force_cube(1'b0), .f(zi));

	assign yi = ybr_q[8] ? yc : ylin_q[5];

	lab_mat u_mat (
		.clk(clk),
		.xi(xi),
		.yi(yi),
		.zi(zi),
		.red(result.red),
		.green(result.green),
		.blue(result.blue)
	);

	assign result.line_end_out = meta_q[LAT-1][1];
	assign result.frame_end_out = meta_q[LAT-1][0];
	assign done = vld_q[LAT-1];

endmodule
